### rtl/bsc_pkg.sv
// shared types and constants for the barometric compensation pipeline
package bsc_pkg;

    localparam int DivW = 64;

    typedef enum logic [1:0] {
        REG_TEMP   = 2'd0,
        REG_PLOW   = 2'd1,
        REG_PHIGH  = 2'd2,
        REG_PLAST  = 2'd3
    } t_reg_idx;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic [31:0] temp;
        logic        dz;
        logic        neg;
    } t_side;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic        dz;
    } t_result;

endpackage

### rtl/bsc_in_if.sv
// input channel: raw temperature and pressure readings
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

### rtl/bsc_out_if.sv
// output channel: compensated temperature and pressure
interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_q8;
    logic               divide_by_zero;

    modport source (output valid, output temperature_centi, output pressure_q8,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q8,
                    input divide_by_zero, output ready);
endinterface

### rtl/barometric_sensor_compensation_top.sv
// top level: fixed-point temperature and pressure compensation pipeline
//
// One raw temperature/pressure pair is taken every clock while the output buffer is not full,
// and one result comes out per pair, in order. Most of the pipeline is the 64-stage radix-2
// divider that forms the pressure quotient; the rest is twelve stages of multiply and add
// before it and eight after it. A two-entry output buffer keeps i_in.ready a registered
// signal. The user must write calibration registers through the plain write port only while
// no beat is in flight; the block itself does not enforce it. The stages that use the
// registers read them directly.
module barometric_sensor_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsc_in_if.sink      i_in,
    bsc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import bsc_pkg::*;

    // x (unsigned 32) times signed 16, full product
    function automatic logic signed [48:0] f_pp_lo(input logic [31:0] x,
                                                   input logic signed [15:0] s);
        logic signed [32:0] xs;
        xs = {1'b0, x};
        return xs * s;
    endfunction

    // x times sign-extended s, low 32 bits only
    function automatic logic [31:0] f_pp_hi(input logic [31:0] x,
                                            input logic signed [15:0] s);
        logic [31:0] se;
        se = {{16{s[15]}}, s};
        return x * se;
    endfunction

    function automatic logic [63:0] f_sx49(input logic signed [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

    function automatic logic [63:0] f_sx16(input logic signed [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pl;
    logic [63:0] r_cal_ph;
    logic [15:0] r_cal_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t  <= '0;
            r_cal_pl <= '0;
            r_cal_ph <= '0;
            r_cal_p9 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TEMP:  r_cal_t  <= i_cfg_data[47:0];
                REG_PLOW:  r_cal_pl <= i_cfg_data;
                REG_PHIGH: r_cal_ph <= i_cfg_data;
                REG_PLAST: r_cal_p9 <= i_cfg_data[15:0];
                default:   r_cal_p9 <= r_cal_p9;
            endcase
        end
    end

    logic        [15:0] w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic        [15:0] w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_cal_t[15:0];
    assign w_t2 = r_cal_t[31:16];
    assign w_t3 = r_cal_t[47:32];
    assign w_p1 = r_cal_pl[15:0];
    assign w_p2 = r_cal_pl[31:16];
    assign w_p3 = r_cal_pl[47:32];
    assign w_p4 = r_cal_pl[63:48];
    assign w_p5 = r_cal_ph[15:0];
    assign w_p6 = r_cal_ph[31:16];
    assign w_p7 = r_cal_ph[47:32];
    assign w_p8 = r_cal_ph[63:48];
    assign w_p9 = r_cal_p9;

    // whole pipe moves unless the output buffer is full
    logic w_en;
    logic r_skid_valid;
    assign w_en       = !r_skid_valid;
    assign i_in.ready = w_en;

    // stage valids
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    logic r_g_valid, r_h_valid, r_i_valid, r_j_valid, r_k_valid, r_l_valid;
    logic r_m_valid, r_n_valid, r_o_valid, r_p_valid, r_q_valid, r_r_valid;
    logic r_s_valid, r_t_valid;
    logic w_div_valid;

    // stage payloads
    logic        [31:0] r_a_ta, r_a_d;
    logic        [19:0] r_a_rawp;
    logic signed [31:0] r_b_a, r_b_dds;
    logic        [19:0] r_b_rawp;
    logic signed [31:0] r_c_a;
    logic        [31:0] r_c_b1;
    logic        [19:0] r_c_rawp;
    logic signed [31:0] r_d_fine;
    logic        [19:0] r_d_rawp;
    logic        [31:0] r_e_temp;
    logic signed [32:0] r_e_v1;
    logic        [19:0] r_e_rawp;
    logic        [63:0] r_f_sq;
    logic signed [48:0] r_f_v1p5, r_f_v1p2;
    logic        [31:0] r_f_temp;
    logic        [19:0] r_f_rawp;
    logic signed [48:0] r_g_lo6, r_g_lo3, r_g_v1p5, r_g_v1p2;
    logic        [31:0] r_g_hi6, r_g_hi3, r_g_temp;
    logic        [19:0] r_g_rawp;
    logic        [63:0] r_h_v2, r_h_w;
    logic signed [48:0] r_h_v1p2;
    logic        [31:0] r_h_temp;
    logic        [19:0] r_h_rawp;
    logic        [63:0] r_i_x, r_i_nd;
    logic        [31:0] r_i_temp;
    logic        [47:0] r_j_xlo;
    logic        [31:0] r_j_xhi, r_j_nhi, r_j_temp;
    logic        [43:0] r_j_nlo;
    logic        [63:0] r_k_den, r_k_num;
    logic        [31:0] r_k_temp;
    logic        [63:0] r_l_an, r_l_ad;
    t_side              r_l_side;
    logic        [63:0] r_m_q;
    logic        [31:0] r_m_temp;
    logic               r_m_dz;
    logic signed [48:0] r_n_ulo, r_n_qlo;
    logic        [31:0] r_n_uhi, r_n_qhi, r_n_temp;
    logic        [63:0] r_n_ps, r_n_q;
    logic               r_n_dz;
    logic        [63:0] r_o_u, r_o_qp8, r_o_ps, r_o_q;
    logic        [31:0] r_o_temp;
    logic               r_o_dz;
    logic        [63:0] r_p_pp0, r_p_w2, r_p_q;
    logic        [31:0] r_p_pp1, r_p_pp2, r_p_temp;
    logic               r_p_dz;
    logic        [63:0] r_q_w1, r_q_w2, r_q_q;
    logic        [31:0] r_q_temp;
    logic               r_q_dz;
    logic        [63:0] r_r_s;
    logic        [31:0] r_r_temp;
    logic               r_r_dz;
    logic        [63:0] r_s_p;
    logic        [31:0] r_s_temp;
    logic               r_s_dz;
    t_result            r_t_res;

    // combinational helpers
    logic [31:0] w_pa, w_dd, w_b1, w_b1s, w_t5;
    logic [32:0] w_v1neg;
    logic [31:0] w_mag;
    logic [63:0] w_v2, w_w, w_wsh, w_x;
    logic [20:0] w_pd;
    logic [63:0] w_nd, w_x1, w_den, w_num, w_an, w_ad;
    logic [63:0] w_div_q, w_q, w_ps, w_qp8s, w_w1raw, w_w1s, w_ssh, w_p;
    t_side       w_div_side;
    t_result     w_t_next;

    assign w_pa   = r_a_ta * {{16{w_t2[15]}}, w_t2};
    assign w_dd   = r_a_d * r_a_d;
    assign w_b1   = r_b_dds * {{16{w_t3[15]}}, w_t3};
    assign w_b1s  = $signed(r_c_b1) >>> 14;
    assign w_t5   = r_d_fine * 32'd5 + 32'd128;
    assign w_v1neg = 33'd0 - r_e_v1;
    assign w_mag  = r_e_v1[32] ? w_v1neg[31:0] : r_e_v1[31:0];
    assign w_v2   = f_sx49(r_g_lo6) + {r_g_hi6, 32'd0} + (f_sx49(r_g_v1p5) << 17)
                  + (f_sx16(w_p4) << 35);
    assign w_w    = f_sx49(r_g_lo3) + {r_g_hi3, 32'd0};
    assign w_wsh  = $signed(r_h_w) >>> 8;
    assign w_x    = w_wsh + (f_sx49(r_h_v1p2) << 12) + 64'h0000_8000_0000_0000;
    assign w_pd   = 21'd1048576 - {1'b0, r_h_rawp};
    assign w_nd   = ({43'd0, w_pd} << 31) - r_h_v2;
    assign w_x1   = {16'd0, r_j_xlo} + {r_j_xhi, 32'd0};
    assign w_den  = $signed(w_x1) >>> 33;
    assign w_num  = {20'd0, r_j_nlo} + {r_j_nhi, 32'd0};
    assign w_an   = r_k_num[63] ? (64'd0 - r_k_num) : r_k_num;
    assign w_ad   = r_k_den[63] ? (64'd0 - r_k_den) : r_k_den;
    assign w_q    = w_div_side.neg ? (64'd0 - w_div_q) : w_div_q;
    assign w_ps   = $signed(r_m_q) >>> 13;
    assign w_qp8s = $signed(r_o_qp8) >>> 19;
    assign w_w1raw = r_p_pp0 + {r_p_pp1 + r_p_pp2, 32'd0};
    assign w_w1s  = $signed(w_w1raw) >>> 25;
    assign w_ssh  = $signed(r_r_s) >>> 8;
    assign w_p    = w_ssh + (f_sx16(w_p7) << 4);

    // saturate to signed 32 bits, zero when the divisor vanished
    always_comb begin
        w_t_next.temp = r_s_temp;
        w_t_next.dz   = r_s_dz;
        if (r_s_dz) begin
            w_t_next.press = '0;
        end else if ((r_s_p[63:31] == '0) || (r_s_p[63:31] == '1)) begin
            w_t_next.press = r_s_p[31:0];
        end else if (r_s_p[63]) begin
            w_t_next.press = 32'h8000_0000;
        end else begin
            w_t_next.press = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0; r_b_valid <= 1'b0; r_c_valid <= 1'b0; r_d_valid <= 1'b0;
            r_e_valid <= 1'b0; r_f_valid <= 1'b0; r_g_valid <= 1'b0; r_h_valid <= 1'b0;
            r_i_valid <= 1'b0; r_j_valid <= 1'b0; r_k_valid <= 1'b0; r_l_valid <= 1'b0;
            r_m_valid <= 1'b0; r_n_valid <= 1'b0; r_o_valid <= 1'b0; r_p_valid <= 1'b0;
            r_q_valid <= 1'b0; r_r_valid <= 1'b0; r_s_valid <= 1'b0; r_t_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid; r_c_valid <= r_b_valid; r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid; r_f_valid <= r_e_valid; r_g_valid <= r_f_valid;
            r_h_valid <= r_g_valid; r_i_valid <= r_h_valid; r_j_valid <= r_i_valid;
            r_k_valid <= r_j_valid; r_l_valid <= r_k_valid;
            r_m_valid <= w_div_valid;
            r_n_valid <= r_m_valid; r_o_valid <= r_n_valid; r_p_valid <= r_o_valid;
            r_q_valid <= r_p_valid; r_r_valid <= r_q_valid; r_s_valid <= r_r_valid;
            r_t_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // temperature terms
            r_a_ta   <= {15'd0, i_in.raw_temperature[19:3]} - {15'd0, w_t1, 1'b0};
            r_a_d    <= {16'd0, i_in.raw_temperature[19:4]} - {16'd0, w_t1};
            r_a_rawp <= i_in.raw_pressure;
            r_b_a    <= $signed(w_pa) >>> 11;
            r_b_dds  <= $signed(w_dd) >>> 12;
            r_b_rawp <= r_a_rawp;
            r_c_a    <= r_b_a;
            r_c_b1   <= w_b1;
            r_c_rawp <= r_b_rawp;
            r_d_fine <= r_c_a + $signed(w_b1s);
            r_d_rawp <= r_c_rawp;
            r_e_temp <= $signed(w_t5) >>> 8;
            r_e_v1   <= {r_d_fine[31], r_d_fine} - 33'd128000;
            r_e_rawp <= r_d_rawp;
            // pressure divisor and dividend
            r_f_sq   <= w_mag * w_mag;
            r_f_v1p5 <= r_e_v1 * w_p5;
            r_f_v1p2 <= r_e_v1 * w_p2;
            r_f_temp <= r_e_temp;
            r_f_rawp <= r_e_rawp;
            r_g_lo6  <= f_pp_lo(r_f_sq[31:0], w_p6);
            r_g_hi6  <= f_pp_hi(r_f_sq[63:32], w_p6);
            r_g_lo3  <= f_pp_lo(r_f_sq[31:0], w_p3);
            r_g_hi3  <= f_pp_hi(r_f_sq[63:32], w_p3);
            r_g_v1p5 <= r_f_v1p5;
            r_g_v1p2 <= r_f_v1p2;
            r_g_temp <= r_f_temp;
            r_g_rawp <= r_f_rawp;
            r_h_v2   <= w_v2;
            r_h_w    <= w_w;
            r_h_v1p2 <= r_g_v1p2;
            r_h_temp <= r_g_temp;
            r_h_rawp <= r_g_rawp;
            r_i_x    <= w_x;
            r_i_nd   <= w_nd;
            r_i_temp <= r_h_temp;
            r_j_xlo  <= r_i_x[31:0] * w_p1;
            r_j_xhi  <= r_i_x[63:32] * {16'd0, w_p1};
            r_j_nlo  <= r_i_nd[31:0] * 12'd3125;
            r_j_nhi  <= r_i_nd[63:32] * 32'd3125;
            r_j_temp <= r_i_temp;
            r_k_den  <= w_den;
            r_k_num  <= w_num;
            r_k_temp <= r_j_temp;
            r_l_an   <= w_an;
            r_l_ad   <= w_ad;
            r_l_side.temp <= r_k_temp;
            r_l_side.dz   <= (r_k_den == '0);
            r_l_side.neg  <= r_k_num[63] ^ r_k_den[63];
            // after the divide
            r_m_q    <= w_q;
            r_m_temp <= w_div_side.temp;
            r_m_dz   <= w_div_side.dz;
            r_n_ulo  <= f_pp_lo(w_ps[31:0], w_p9);
            r_n_uhi  <= f_pp_hi(w_ps[63:32], w_p9);
            r_n_qlo  <= f_pp_lo(r_m_q[31:0], w_p8);
            r_n_qhi  <= f_pp_hi(r_m_q[63:32], w_p8);
            r_n_ps   <= w_ps;
            r_n_q    <= r_m_q;
            r_n_temp <= r_m_temp;
            r_n_dz   <= r_m_dz;
            r_o_u    <= f_sx49(r_n_ulo) + {r_n_uhi, 32'd0};
            r_o_qp8  <= f_sx49(r_n_qlo) + {r_n_qhi, 32'd0};
            r_o_ps   <= r_n_ps;
            r_o_q    <= r_n_q;
            r_o_temp <= r_n_temp;
            r_o_dz   <= r_n_dz;
            r_p_pp0  <= r_o_u[31:0] * r_o_ps[31:0];
            r_p_pp1  <= r_o_u[31:0] * r_o_ps[63:32];
            r_p_pp2  <= r_o_u[63:32] * r_o_ps[31:0];
            r_p_w2   <= w_qp8s;
            r_p_q    <= r_o_q;
            r_p_temp <= r_o_temp;
            r_p_dz   <= r_o_dz;
            r_q_w1   <= w_w1s;
            r_q_w2   <= r_p_w2;
            r_q_q    <= r_p_q;
            r_q_temp <= r_p_temp;
            r_q_dz   <= r_p_dz;
            r_r_s    <= r_q_q + r_q_w1 + r_q_w2;
            r_r_temp <= r_q_temp;
            r_r_dz   <= r_q_dz;
            r_s_p    <= w_p;
            r_s_temp <= r_r_temp;
            r_s_dz   <= r_r_dz;
            r_t_res  <= w_t_next;
        end
    end

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_l_valid),
        .i_num   (r_l_an),
        .i_den   (r_l_ad),
        .i_side  (r_l_side),
        .o_valid (w_div_valid),
        .o_quo   (w_div_q),
        .o_side  (w_div_side)
    );

    // output register plus skid entry
    logic    r_out_valid;
    t_result r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_en && r_t_valid) begin
            if (r_out_valid && !o_out.ready) begin
                r_skid_valid <= 1'b1;
                r_skid       <= r_t_res;
            end else begin
                r_out_valid <= 1'b1;
                r_out       <= r_t_res;
            end
        end else if (r_out_valid && o_out.ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_centi = r_out.temp;
    assign o_out.pressure_q8       = r_out.press;
    assign o_out.divide_by_zero    = r_out.dz;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_dz_forces_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_by_zero) |-> (o_out.pressure_q8 == '0))
        else $error("zero divisor beat carries nonzero pressure");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_t_valid) && $stable(r_l_valid) && $stable(r_a_valid)))
        else $error("pipeline moved while output buffer full");

endmodule

### rtl/bsc_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module bsc_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [63:0]            i_num,
    input  logic [63:0]            i_den,
    input  bsc_pkg::t_side         i_side,
    output logic                   o_valid,
    output logic [63:0]            o_quo,
    output bsc_pkg::t_side         o_side
);
    import bsc_pkg::*;

    logic [DivW-1:0] w_rem [0:DivW-1];
    logic [DivW-1:0] w_num [0:DivW-1];
    logic [DivW-1:0] w_den [0:DivW-1];
    t_side           w_side [0:DivW-1];
    logic            w_vld [0:DivW-1];

    logic [DivW-1:0] r_rem [0:DivW-1];
    logic [DivW-1:0] r_num [0:DivW-1];
    logic [DivW-1:0] r_den [0:DivW-1];
    t_side           r_side [0:DivW-1];
    logic            r_vld [0:DivW-1];

    for (genvar k = 0; k < DivW; k++) begin : g_stage
        logic [DivW:0] w_trial;
        logic [DivW:0] w_diff;

        if (k == 0) begin : g_first
            assign w_rem[k]  = '0;
            assign w_num[k]  = i_num;
            assign w_den[k]  = i_den;
            assign w_side[k] = i_side;
            assign w_vld[k]  = i_valid;
        end else begin : g_next
            assign w_rem[k]  = r_rem[k-1];
            assign w_num[k]  = r_num[k-1];
            assign w_den[k]  = r_den[k-1];
            assign w_side[k] = r_side[k-1];
            assign w_vld[k]  = r_vld[k-1];
        end

        // bring down the next dividend bit and try a subtract
        assign w_trial = {w_rem[k], w_num[k][DivW-1]};
        assign w_diff  = w_trial - {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_diff[DivW]) begin
                    r_rem[k] <= w_diff[DivW-1:0];
                    r_num[k] <= {w_num[k][DivW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_trial[DivW-1:0];
                    r_num[k] <= {w_num[k][DivW-2:0], 1'b0};
                end
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_vld[DivW-1];
    assign o_quo   = r_num[DivW-1];
    assign o_side  = r_side[DivW-1];

endmodule

### dv/tb_barometric_sensor_compensation_top.sv
// testbench for the barometric compensation pipeline: random beats checked against a predictor
module tb_barometric_sensor_compensation_top;
    import bsc_pkg::*;

    class compensation_scoreboard;
        logic [63:0] cal_temp;
        logic [63:0] cal_plow;
        logic [63:0] cal_phigh;
        logic [63:0] cal_plast;
        t_result     pending_q[$];
        int          mismatches;
        int          checked;
        int          zero_div_seen;
        int          saturated_seen;

        function new();
            cal_temp = '0;
            cal_plow = '0;
            cal_phigh = '0;
            cal_plast = '0;
            mismatches = 0;
            checked = 0;
            zero_div_seen = 0;
            saturated_seen = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] val);
            case (idx)
                REG_TEMP: cal_temp = {16'd0, val[47:0]};
                REG_PLOW: cal_plow = val;
                REG_PHIGH: cal_phigh = val;
                REG_PLAST: cal_plast = {48'd0, val[15:0]};
            endcase
        endfunction

        function longint sx16(logic [63:0] r, int pos);
            logic [15:0] s;
            s = r[pos +: 16];
            return longint'(signed'(s));
        endfunction

        // signed divide truncating toward zero, wraps on the one overflow case
        function longint div_trunc(longint n, longint d);
            logic [63:0] an;
            logic [63:0] ad;
            logic [63:0] q;
            an = (n < 0) ? 64'd0 - n : n;
            ad = (d < 0) ? 64'd0 - d : d;
            q = an / ad;
            return ((n < 0) != (d < 0)) ? longint'(64'd0 - q) : longint'(q);
        endfunction

        function t_result compensate(logic [19:0] rt, logic [19:0] rp);
            t_result res;
            logic signed [31:0] t1, t2, t3, rt32, tmp, a, b, d, fine, temp;
            longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
            longint v1, v2, p, n, ps, w1, w2;
            t1 = {16'd0, cal_temp[15:0]};
            t2 = 32'(sx16(cal_temp, 16));
            t3 = 32'(sx16(cal_temp, 32));
            rt32 = {12'd0, rt};
            tmp = (rt32 >>> 3) - (t1 <<< 1);
            tmp = tmp * t2;
            a = tmp >>> 11;
            d = (rt32 >>> 4) - t1;
            tmp = d * d;
            tmp = tmp >>> 12;
            tmp = tmp * t3;
            b = tmp >>> 14;
            fine = a + b;
            tmp = fine * 32'sd5 + 32'sd128;
            temp = tmp >>> 8;

            p1 = longint'({48'd0, cal_plow[15:0]});
            p2 = sx16(cal_plow, 16);
            p3 = sx16(cal_plow, 32);
            p4 = sx16(cal_plow, 48);
            p5 = sx16(cal_phigh, 0);
            p6 = sx16(cal_phigh, 16);
            p7 = sx16(cal_phigh, 32);
            p8 = sx16(cal_phigh, 48);
            p9 = sx16(cal_plast, 0);

            v1 = longint'(fine) - 64'sd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;

            res.temp = temp;
            res.press = '0;
            res.dz = 1'b0;
            if (v1 == 0) begin
                res.dz = 1'b1;
            end else begin
                p = 64'sd1048576 - longint'({44'd0, rp});
                n = ((p <<< 31) - v2) * 64'sd3125;
                p = div_trunc(n, v1);
                ps = p >>> 13;
                w1 = (p9 * ps * ps) >>> 25;
                w2 = (p8 * p) >>> 19;
                p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
                if (p < -64'sd2147483648) begin
                    p = -64'sd2147483648;
                end else if (p > 64'sd2147483647) begin
                    p = 64'sd2147483647;
                end
                res.press = p[31:0];
            end
            return res;
        endfunction

        function void note_reading(logic [19:0] rt, logic [19:0] rp);
            pending_q.push_back(compensate(rt, rp));
        endfunction

        function void check_result(logic [31:0] temp, logic [31:0] press, logic dz);
            t_result exp_r;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: temp %0d press %0d dz %0b",
                       $signed(temp), $signed(press), dz);
                mismatches++;
                return;
            end
            exp_r = pending_q.pop_front();
            checked++;
            if (exp_r.dz) zero_div_seen++;
            if (!exp_r.dz && (exp_r.press == 32'h7fffffff || exp_r.press == 32'h80000000))
                saturated_seen++;
            if (temp !== exp_r.temp) begin
                $error("temperature_centi: expected %0d, got %0d",
                       $signed(exp_r.temp), $signed(temp));
                mismatches++;
            end
            if (press !== exp_r.press) begin
                $error("pressure_q8: expected %0d, got %0d",
                       $signed(exp_r.press), $signed(press));
                mismatches++;
            end
            if (dz !== exp_r.dz) begin
                $error("divide_by_zero: expected %0b, got %0b", exp_r.dz, dz);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    bsc_in_if  in_if();
    bsc_out_if out_if();

    barometric_sensor_compensation_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int DrainCycles = 100;
    localparam int StallLimit  = 3000;

    compensation_scoreboard sb = new();
    bit hold_req;
    bit no_idle;
    int sent;
    int idle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_TEMP;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.raw_temperature = '0;
        in_if.raw_pressure = '0;
        out_if.ready = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: random back-pressure plus one long hold on request
    initial begin
        int rx_gap;
        rx_gap = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (rx_gap > 0) begin
                out_if.ready <= 1'b0;
                rx_gap--;
            end else begin
                out_if.ready <= 1'b1;
                rx_gap = gap_len();
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_reading(in_if.raw_temperature, in_if.raw_pressure);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.temperature_centi, out_if.pressure_q8,
                                out_if.divide_by_zero);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= StallLimit) begin
                $display("timeout: no beat for %0d cycles", StallLimit);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
        int g;
        in_if.valid <= 1'b1;
        in_if.raw_temperature <= rt;
        in_if.raw_pressure <= rp;
        do @(posedge i_clk); while (!in_if.ready);
        sent++;
        g = gap_len();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic load_cal(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                            logic [63:0] pz);
        logic [63:0] vals[4];
        vals = '{tc, pl, ph, pz};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 2'(k);
            i_cfg_data <= vals[k];
            sb.set_reg(t_reg_idx'(k), vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_raw(logic [19:0] typical);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return typical + 20'($urandom_range(0, 65535)) - 20'd32768;
        if (r < 6) return ($urandom_range(0, 1) == 1) ? 20'hfffff : 20'h0;
        return 20'($urandom_range(0, 20'hfffff));
    endfunction

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
            send_reading(pick_raw(20'd519888), pick_raw(20'd415148));
    endtask

    localparam logic [63:0] TypTemp  = {16'd0, 16'hfc18, 16'd26435, 16'd27504};
    localparam logic [63:0] TypPLow  = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
    localparam logic [63:0] TypPHigh = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};

    initial begin
        logic [19:0] edge_t[3];
        logic [19:0] edge_p[3];
        edge_t = '{20'h0, 20'hfffff, 20'd519888};
        edge_p = '{20'h0, 20'hfffff, 20'd415148};
        hold_req = 1'b0;
        no_idle = 1'b0;
        sent = 0;
        idle_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero calibration after reset: every beat takes the zero-divisor path
        send_reading(20'h0, 20'h0);
        send_reading(20'hfffff, 20'hfffff);
        drain();

        // typical calibration, field extremes
        load_cal(TypTemp, TypPLow, TypPHigh, 64'd6000);
        foreach (edge_t[i])
            foreach (edge_p[j])
                send_reading(edge_t[i], edge_p[j]);
        drain();

        // coefficient extremes, full-width data to exercise register masking
        load_cal(64'hffff_8000_7fff_ffff, 64'h8000_7fff_8000_ffff,
                 64'h7fff_8000_7fff_8000, 64'hffff_ffff_ffff_8000);
        foreach (edge_t[i]) send_reading(edge_t[i], edge_p[i]);
        send_reading(20'd12345, 20'hfffff);
        drain();
        load_cal(64'hffff_7fff_8000_0000, 64'h7fff_8000_7fff_0001,
                 64'h8000_7fff_8000_7fff, 64'h0000_0000_0000_7fff);
        foreach (edge_t[i]) send_reading(edge_t[i], edge_p[i]);
        drain();

        // typical calibration, no idling, then a long output hold to fill the pipe
        load_cal(TypTemp, TypPLow, TypPHigh, 64'd6000);
        no_idle = 1'b1;
        random_burst(150);
        hold_req = 1'b1;
        random_burst(250);
        no_idle = 1'b0;
        random_burst(200);
        drain();

        // random calibrations, alternating near-typical and fully random values
        for (int ph = 0; ph < 8; ph++) begin
            if (ph[0])
                load_cal({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            else
                load_cal(TypTemp ^ 64'($urandom_range(0, 255)),
                         TypPLow ^ 64'($urandom_range(0, 255)),
                         TypPHigh ^ {8'($urandom_range(0, 255)), 56'd0},
                         64'($urandom_range(0, 65535)));
            no_idle = (ph == 5);
            random_burst(150);
            drain();
        end

        $display("sent %0d readings, checked %0d results over several calibrations",
                 sent, sb.checked);
        $display("zero-divisor results %0d, saturated pressures %0d",
                 sb.zero_div_seen, sb.saturated_seen);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### barometric_sensor_compensation_top.f
rtl/bsc_pkg.sv
rtl/bsc_in_if.sv
rtl/bsc_out_if.sv
rtl/bsc_div.sv
rtl/barometric_sensor_compensation_top.sv
dv/tb_barometric_sensor_compensation_top.sv
